// File: src/owrs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// owrs_pkg
// Shared types and codes for the 1-Wire Search ROM decision engine.
// ============================================================================
package owrs_pkg;

    localparam int ROM_W    = 64;
    localparam int BITN_W   = 7;
    localparam int FOUND_W  = 4;
    localparam int INDEX_W  = 3;

    typedef enum logic [1:0] {
        REQ_RESTART    = 2'd0,
        REQ_PASS_START = 2'd1,
        REQ_BIT_PAIR   = 2'd2,
        REQ_READ_ROM   = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_ACK         = 3'd0,
        ST_BIT_TAKEN   = 3'd1,
        ST_FOUND_MORE  = 3'd2,
        ST_COMPLETE    = 3'd3,
        ST_NO_PRESENCE = 3'd4,
        ST_NO_RESPONSE = 3'd5,
        ST_LIMIT       = 3'd6,
        ST_INVALID     = 3'd7
    } status_t;

    // One result record as it moves through the result stages.
    typedef struct packed {
        logic               dir_bit;
        status_t            status;
        logic [ROM_W-1:0]   rom_code;
        logic [FOUND_W-1:0] found_count;
        logic [BITN_W-1:0]  bit_number;
        logic               rd_hit;     // rom_code comes from the table read
    } res_t;

endpackage

// File: src/owrs_if.sv
`timescale 1ns / 1ps
// ============================================================================
// owrs_req_if / owrs_rsp_if
// Valid/ready channels for search requests and their results.
// ============================================================================
interface owrs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
    logic [2:0] device_index;

    modport source (output valid, output req_type, output presence, output id_bit,
                    output cmp_bit, output device_index, input ready);
    modport sink   (input valid, input req_type, input presence, input id_bit,
                    input cmp_bit, input device_index, output ready);
endinterface

interface owrs_rsp_if;
    logic        valid;
    logic        ready;
    logic        dir_bit;
    logic [2:0]  status;
    logic [63:0] rom_code;
    logic [3:0]  found_count;
    logic [6:0]  bit_number;

    modport source (output valid, output dir_bit, output status, output rom_code,
                    output found_count, output bit_number, input ready);
    modport sink   (input valid, input dir_bit, input status, input rom_code,
                    input found_count, input bit_number, output ready);
endinterface

// File: src/onewire_rom_search_engine_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// onewire_rom_search_engine_unit
// Decision core of the 1-Wire Search ROM algorithm with a table of found ROMs.
// ============================================================================
// Each request transaction that is taken gives exactly one result transaction:
// the search state (last discrepancy, last zero, bit position, working ROM,
// device count) is updated in the same cycle the request is taken, so
// back-to-back bit pairs run at one per clock unless the output stalls, and the
// result then passes a stage register (which also catches the registered ROM
// table read) and an output register. With the output stalled the block still
// takes one more request into the stage register before ready drops. The ROM
// table has MAX_DEVICE_COUNT entries in a single-port-write, single-read array;
// it needs no clearing after reset since only entries below the found count
// are ever returned. found_count reports the low four bits of the device count.
// ============================================================================
module onewire_rom_search_engine_unit
    import owrs_pkg::*;
#(
    parameter int MAX_DEVICE_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    owrs_req_if.sink    req,
    owrs_rsp_if.source  rsp
);

    localparam int CW   = $clog2(MAX_DEVICE_COUNT + 1);
    localparam int AW   = (MAX_DEVICE_COUNT > 1) ? $clog2(MAX_DEVICE_COUNT) : 1;
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    // ------------------------------------------------------------------
    // Search state
    // ------------------------------------------------------------------
    logic [BITN_W-1:0] last_disc_reg, last_disc_next;
    logic [BITN_W-1:0] last_zero_reg, last_zero_next;
    logic [BITN_W-1:0] bit_pos_reg,   bit_pos_next;
    logic [ROM_W-1:0]  work_rom_reg,  work_rom_next;
    logic [CW-1:0]     dev_cnt_reg,   dev_cnt_next;
    logic              pass_act_reg,  pass_act_next;
    logic              done_reg,      done_next;

    // Result stage and output register
    logic              s1_vld_reg;
    res_t              s1_res_reg;
    res_t              s1_fwd;
    logic [ROM_W-1:0]  mem_q_reg;
    logic              out_vld_reg;
    res_t              out_res_reg;

    logic              req_acc;
    logic              s1_move;
    res_t              res;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    logic [ROM_W-1:0]  rom_mem [MAX_DEVICE_COUNT];

    // The stage register frees up whenever it can hand off to the output.
    assign s1_move   = s1_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !s1_vld_reg || s1_move;
    assign req_acc   = req.valid && req.ready;

    assign rd_addr   = AW'(req.device_index);
    assign wr_addr   = AW'(dev_cnt_reg);

    // ------------------------------------------------------------------
    // Decision logic: next state and result for the request at the port
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [BITN_W-1:0] n;
        logic [5:0]        bidx;
        logic              d;

        last_disc_next = last_disc_reg;
        last_zero_next = last_zero_reg;
        bit_pos_next   = bit_pos_reg;
        work_rom_next  = work_rom_reg;
        dev_cnt_next   = dev_cnt_reg;
        pass_act_next  = pass_act_reg;
        done_next      = done_reg;
        wr_en          = 1'b0;

        n    = bit_pos_reg + BITN_W'(1);
        bidx = bit_pos_reg[5:0];
        d    = 1'b0;

        res          = '0;
        res.status   = ST_ACK;

        unique case (req_type_t'(req.req_type))
            REQ_RESTART:
            begin
                last_disc_next = '0;
                last_zero_next = '0;
                bit_pos_next   = '0;
                work_rom_next  = '0;
                dev_cnt_next   = '0;
                pass_act_next  = 1'b0;
                done_next      = 1'b0;
            end
            REQ_PASS_START:
            begin
                priority if (done_reg)
                begin
                    res.status = ST_COMPLETE;
                end
                else if (dev_cnt_reg == CW'(MAX_DEVICE_COUNT))
                begin
                    res.status = ST_LIMIT;
                end
                else if (!req.presence)
                begin
                    last_disc_next = '0;
                    last_zero_next = '0;
                    bit_pos_next   = '0;
                    work_rom_next  = '0;
                    dev_cnt_next   = '0;
                    pass_act_next  = 1'b0;
                    done_next      = 1'b0;
                    res.status     = ST_NO_PRESENCE;
                end
                else
                begin
                    // a pass already open is simply restarted
                    pass_act_next = 1'b1;
                    bit_pos_next  = '0;
                    last_zero_next = '0;
                end
            end
            REQ_BIT_PAIR:
            begin
                priority if (!pass_act_reg || bit_pos_reg >= BITN_W'(ROM_W))
                begin
                    res.status = ST_INVALID;
                end
                else if (req.id_bit && req.cmp_bit)
                begin
                    // nobody answered: drop the whole search
                    last_disc_next = '0;
                    last_zero_next = '0;
                    bit_pos_next   = '0;
                    work_rom_next  = '0;
                    dev_cnt_next   = '0;
                    pass_act_next  = 1'b0;
                    done_next      = 1'b0;
                    res.status     = ST_NO_RESPONSE;
                end
                else
                begin
                    if (req.id_bit != req.cmp_bit)
                    begin
                        d = req.id_bit;
                    end
                    else
                    begin
                        // discrepancy: follow the previous path, branch at last one
                        priority if (n < last_disc_reg)
                            d = work_rom_reg[bidx];
                        else
                            d = (n == last_disc_reg);
                        if (!d)
                            last_zero_next = n;
                    end
                    work_rom_next[bidx] = d;
                    bit_pos_next        = n;
                    res.dir_bit         = d;
                    res.bit_number      = n;
                    if (n < BITN_W'(ROM_W))
                    begin
                        res.status = ST_BIT_TAKEN;
                    end
                    else
                    begin
                        last_disc_next = last_zero_next;
                        if (last_zero_next == '0)
                            done_next = 1'b1;
                        if (dev_cnt_reg != CW'(MAX_DEVICE_COUNT))
                        begin
                            wr_en        = 1'b1;
                            dev_cnt_next = dev_cnt_reg + CW'(1);
                        end
                        pass_act_next = 1'b0;
                        res.rom_code  = work_rom_next;
                        priority if (done_next)
                            res.status = ST_COMPLETE;
                        else if (dev_cnt_next == CW'(MAX_DEVICE_COUNT))
                            res.status = ST_LIMIT;
                        else
                            res.status = ST_FOUND_MORE;
                    end
                end
            end
            REQ_READ_ROM:
            begin
                if (CMPW'(req.device_index) < CMPW'(dev_cnt_reg))
                    res.rd_hit = 1'b1;
                else
                    res.status = ST_INVALID;
            end
            default:
            begin
                res.status = ST_INVALID;
            end
        endcase

        res.found_count = FOUND_W'(dev_cnt_next);
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_disc_reg <= '0;
            last_zero_reg <= '0;
            bit_pos_reg   <= '0;
            work_rom_reg  <= '0;
            dev_cnt_reg   <= '0;
            pass_act_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else if (req_acc)
        begin
            last_disc_reg <= last_disc_next;
            last_zero_reg <= last_zero_next;
            bit_pos_reg   <= bit_pos_next;
            work_rom_reg  <= work_rom_next;
            dev_cnt_reg   <= dev_cnt_next;
            pass_act_reg  <= pass_act_next;
            done_reg      <= done_next;
        end
    end

    // ROM table: write at the found count, registered read at the index
    always_ff @(posedge clk)
    begin
        if (req_acc && wr_en)
            rom_mem[wr_addr] <= work_rom_next;
        if (req_acc)
            mem_q_reg <= rom_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Result stage and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_acc)
                s1_vld_reg <= 1'b1;
            else if (s1_move)
                s1_vld_reg <= 1'b0;

            if (s1_move)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // stage result with the table read merged in for a read hit
    always_comb
    begin
        s1_fwd = s1_res_reg;
        if (s1_res_reg.rd_hit)
            s1_fwd.rom_code = mem_q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
            s1_res_reg <= res;
        if (s1_move)
            out_res_reg <= s1_fwd;
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.dir_bit     = out_res_reg.dir_bit;
    assign rsp.status      = out_res_reg.status;
    assign rsp.rom_code    = out_res_reg.rom_code;
    assign rsp.found_count = out_res_reg.found_count;
    assign rsp.bit_number  = out_res_reg.bit_number;

`ifndef SYNTHESIS
    // A stage result that cannot move on is kept, not dropped.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && !s1_move |=> s1_vld_reg)
        else $error("stage result lost while output stalled");

    // An open pass never runs past the last ROM bit.
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pass_act_reg |-> bit_pos_reg < BITN_W'(ROM_W))
        else $error("open pass beyond bit 64");

    // The found count never passes the table size.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dev_cnt_reg <= CW'(MAX_DEVICE_COUNT))
        else $error("device count beyond table size");

    // A taken bit reports a position inside the ROM.
    a_bit_taken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_BIT_TAKEN
            |-> rsp.bit_number != '0 && rsp.bit_number < BITN_W'(ROM_W))
        else $error("bit taken with bad position");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the 1-Wire Search ROM decision engine. Simulated
// devices answer each bit pair as a wired-AND bus would. A cycle-free
// predictor tracks the search state and forms the expected result of every
// request transaction. Each result transaction is checked field by field
// against the oldest expected one. Both sides of the block idle at random.
// ============================================================================
module testbench;
    import owrs_pkg::*;

    localparam int TABLE_DEPTH     = 8;     // ROM table entries in the block
    localparam int ITEM_TARGET     = 1950;  // stimulus stops near this count
    localparam int MAX_BUS_DEVICES = 12;

    // Expected content of one result transaction
    typedef struct packed {
        logic               dir_bit;
        status_t            status;
        logic [ROM_W-1:0]   rom_code;
        logic [FOUND_W-1:0] found_count;
        logic [BITN_W-1:0]  bit_number;
    } search_rsp_t;

    logic clk;
    logic rst_n;

    owrs_req_if req_bus ();
    owrs_rsp_if rsp_bus ();

    onewire_rom_search_engine_unit #(
        .MAX_DEVICE_COUNT (TABLE_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the search registers and ROM table
    // ------------------------------------------------------------------------
    logic [BITN_W-1:0]  mdl_last_disc;
    logic [BITN_W-1:0]  mdl_last_zero;
    logic [BITN_W-1:0]  mdl_bit_pos;    // bits decided in the open pass
    logic [ROM_W-1:0]   mdl_work_rom;
    logic [FOUND_W-1:0] mdl_found;
    logic               mdl_in_pass;
    logic               mdl_done;
    logic [ROM_W-1:0]   mdl_rom_table [TABLE_DEPTH];

    search_rsp_t        expected_rsp [$];   // oldest expectation at the front
    logic [ROM_W-1:0]   bus_devices [$];    // ROMs of the devices on the bus

    int items_sent;
    int results_seen;
    int mismatches;
    int searches_run;
    int roms_stored;

    bit src_quiet;      // sender never idles while set
    bit sink_quiet;     // receiver never stalls while set
    bit req_up;         // mirrors the value last scheduled onto req valid

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin : watchdog
        #10_000_000;
        $display("FAIL onewire_rom_search_engine_unit");
        $finish;
    end

    // Mostly no gap, sometimes a few cycles, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_search_state();
        mdl_last_disc = '0;
        mdl_last_zero = '0;
        mdl_bit_pos   = '0;
        mdl_work_rom  = '0;
        mdl_found     = '0;
        mdl_in_pass   = 1'b0;
        mdl_done      = 1'b0;
    endfunction

    // Advances the search state by one request and returns the result it gives
    function automatic search_rsp_t predict_search(req_type_t kind, logic pres,
                                                   logic idb, logic cmpb,
                                                   logic [INDEX_W-1:0] idx);
        search_rsp_t        r;
        logic [BITN_W-1:0]  n;
        logic               d;
        r        = '0;
        r.status = ST_ACK;
        case (kind)
            REQ_RESTART:
                clear_search_state();
            REQ_PASS_START:
            begin
                if (mdl_done)
                    r.status = ST_COMPLETE;
                else if (mdl_found >= TABLE_DEPTH)
                    r.status = ST_LIMIT;
                else if (!pres)
                begin
                    clear_search_state();
                    r.status = ST_NO_PRESENCE;
                end
                else
                begin
                    // a pass already open is simply started over
                    mdl_in_pass   = 1'b1;
                    mdl_bit_pos   = '0;
                    mdl_last_zero = '0;
                end
            end
            REQ_BIT_PAIR:
            begin
                if (!mdl_in_pass || mdl_bit_pos >= ROM_W)
                    r.status = ST_INVALID;
                else if (idb && cmpb)
                begin
                    // nobody answered: the whole search is dropped
                    clear_search_state();
                    r.status = ST_NO_RESPONSE;
                end
                else
                begin
                    n = mdl_bit_pos + 1'b1;
                    if (idb != cmpb)
                        d = idb;
                    else
                    begin
                        // discrepancy: follow the previous path below the last
                        // discrepancy, take 1 at it, take 0 beyond it
                        if (n < mdl_last_disc)
                            d = mdl_work_rom[n - 1'b1];
                        else
                            d = (n == mdl_last_disc);
                        if (!d)
                            mdl_last_zero = n;
                    end
                    mdl_work_rom[n - 1'b1] = d;
                    mdl_bit_pos  = n;
                    r.dir_bit    = d;
                    r.bit_number = n;
                    if (n < ROM_W)
                        r.status = ST_BIT_TAKEN;
                    else
                    begin
                        mdl_last_disc = mdl_last_zero;
                        if (mdl_last_disc == 0)
                            mdl_done = 1'b1;
                        if (mdl_found < TABLE_DEPTH)
                        begin
                            mdl_rom_table[mdl_found[INDEX_W-1:0]] = mdl_work_rom;
                            mdl_found = mdl_found + 1'b1;
                            roms_stored++;
                        end
                        mdl_in_pass = 1'b0;
                        r.rom_code  = mdl_work_rom;
                        if (mdl_done)
                            r.status = ST_COMPLETE;
                        else if (mdl_found >= TABLE_DEPTH)
                            r.status = ST_LIMIT;
                        else
                            r.status = ST_FOUND_MORE;
                    end
                end
            end
            default:
            begin
                if (idx < mdl_found)
                    r.rom_code = mdl_rom_table[idx];
                else
                    r.status = ST_INVALID;
            end
        endcase
        r.found_count = mdl_found;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side: one transaction per call, valid left high on return so
    // back-to-back requests need no extra cycle
    // ------------------------------------------------------------------------
    task automatic send_req(input req_type_t kind, input logic pres, input logic idb,
                            input logic cmpb, input logic [INDEX_W-1:0] idx,
                            output search_rsp_t want);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        // fields the request type ignores still carry random values
        if (kind != REQ_PASS_START)
            pres = 1'($urandom_range(0, 1));
        if (kind != REQ_BIT_PAIR)
        begin
            idb  = 1'($urandom_range(0, 1));
            cmpb = 1'($urandom_range(0, 1));
        end
        if (kind != REQ_READ_ROM)
            idx = 3'($urandom_range(0, 7));
        if (gap > 0)
        begin
            if (req_up)
            begin
                req_bus.valid <= 1'b0;
                req_up = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= kind;
        req_bus.presence     <= pres;
        req_bus.id_bit       <= idb;
        req_bus.cmp_bit      <= cmpb;
        req_bus.device_index <= idx;
        req_up = 1'b1;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        want = predict_search(kind, pres, idb, cmpb, idx);
        expected_rsp.push_back(want);
        items_sent++;
    endtask

    // Holds the sender off until every outstanding result has arrived
    task automatic wait_all_results();
        if (req_up)
        begin
            req_bus.valid <= 1'b0;
            req_up = 1'b0;
        end
        do
            @(posedge clk);
        while (expected_rsp.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random backpressure and the scoreboard
    // ------------------------------------------------------------------------
    initial
    begin : rsp_pacing
        int hold;
        hold = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (!sink_quiet)
                    hold = pick_gap();
            end
        end
    end

    task automatic report_field(input string label, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        search_rsp_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            results_seen++;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result transaction with none expected, expected none, actual status %0d",
                         $time, rsp_bus.status);
            end
            else
            begin
                want = expected_rsp.pop_front();
                report_field("dir_bit",     64'(want.dir_bit),     64'(rsp_bus.dir_bit));
                report_field("status",      64'(want.status),      64'(rsp_bus.status));
                report_field("rom_code",    want.rom_code,         rsp_bus.rom_code);
                report_field("found_count", 64'(want.found_count), 64'(rsp_bus.found_count));
                report_field("bit_number",  64'(want.bit_number),  64'(rsp_bus.bit_number));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Simulated bus population
    // ------------------------------------------------------------------------
    // flips == 0: independent ROMs; otherwise each ROM is a shared base with a
    // few bits flipped, which packs the discrepancies into few positions
    function automatic void load_devices(int count, int flips);
        logic [ROM_W-1:0] base;
        logic [ROM_W-1:0] cand;
        bit               dup;
        base = {$urandom, $urandom};
        bus_devices.delete();
        while (bus_devices.size() < count)
        begin
            if (flips == 0)
                cand = {$urandom, $urandom};
            else
            begin
                cand = base;
                repeat ($urandom_range(1, flips))
                    cand[$urandom_range(0, ROM_W-1)] ^= 1'b1;
            end
            dup = 1'b0;
            foreach (bus_devices[k])
                if (bus_devices[k] == cand)
                    dup = 1'b1;
            if (!dup)
                bus_devices.push_back(cand);
        end
    endfunction

    // Full search over bus_devices. Devices drop out as soon as the written
    // direction differs from their own bit, exactly as on a real bus; an empty
    // bus reads back as both bits high. noise_pct mixes in reads, restarted
    // passes, corrupted bit pairs and lost presence pulses. No new pass starts
    // once the item budget is spent.
    task automatic run_search(input int noise_pct);
        search_rsp_t got;
        bit          alive [MAX_BUS_DEVICES];
        logic        idb;
        logic        cmpb;
        int          passes;
        searches_run++;
        send_req(REQ_RESTART, 1'b0, 1'b0, 1'b0, '0, got);
        passes = 0;
        while (passes < 40 && !mdl_done && mdl_found < TABLE_DEPTH &&
               items_sent < ITEM_TARGET)
        begin
            passes++;
            send_req(REQ_PASS_START, $urandom_range(0, 99) >= noise_pct / 4,
                     1'b0, 1'b0, '0, got);
            foreach (alive[k])
                alive[k] = 1'b1;
            while (mdl_in_pass)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                begin
                    case ($urandom_range(0, 2))
                        0: send_req(REQ_READ_ROM, 1'b0, 1'b0, 1'b0,
                                    3'($urandom_range(0, 7)), got);
                        1:
                        begin
                            send_req(REQ_PASS_START, 1'b1, 1'b0, 1'b0, '0, got);
                            foreach (alive[k])
                                alive[k] = 1'b1;
                        end
                        default: send_req(REQ_BIT_PAIR, 1'b0, 1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)), '0, got);
                    endcase
                end
                else
                begin
                    // wired-AND of the true bits and of their complements
                    idb  = 1'b1;
                    cmpb = 1'b1;
                    foreach (bus_devices[k])
                        if (alive[k])
                        begin
                            if (bus_devices[k][mdl_bit_pos])
                                cmpb = 1'b0;
                            else
                                idb = 1'b0;
                        end
                    send_req(REQ_BIT_PAIR, 1'b0, idb, cmpb, '0, got);
                end
                if (got.bit_number != 0)
                    foreach (bus_devices[k])
                        if (bus_devices[k][got.bit_number - 1'b1] != got.dir_bit)
                            alive[k] = 1'b0;
            end
        end
        // one more pass start shows the finished or full state, then read back
        send_req(REQ_PASS_START, 1'b1, 1'b0, 1'b0, '0, got);
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_req(REQ_READ_ROM, 1'b0, 1'b0, 1'b0, 3'(k), got);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Short hand-made sequence: every request type, requests out of order,
    // aborted passes and reads of entries not yet found
    task automatic test_directed_cases();
        search_rsp_t got;
        src_quiet  = 1'b1;
        sink_quiet = 1'b1;
        send_req(REQ_RESTART,    1'b0, 1'b0, 1'b0, 3'd0, got);
        send_req(REQ_READ_ROM,   1'b0, 1'b0, 1'b0, 3'd0, got);   // nothing found
        send_req(REQ_READ_ROM,   1'b0, 1'b0, 1'b0, 3'd7, got);
        send_req(REQ_BIT_PAIR,   1'b0, 1'b0, 1'b1, 3'd0, got);   // no pass open
        send_req(REQ_PASS_START, 1'b0, 1'b0, 1'b0, 3'd0, got);   // no presence
        send_req(REQ_PASS_START, 1'b1, 1'b0, 1'b0, 3'd0, got);
        send_req(REQ_BIT_PAIR,   1'b0, 1'b1, 1'b0, 3'd0, got);
        send_req(REQ_BIT_PAIR,   1'b0, 1'b0, 1'b1, 3'd0, got);
        send_req(REQ_BIT_PAIR,   1'b0, 1'b0, 1'b0, 3'd0, got);   // discrepancy
        send_req(REQ_READ_ROM,   1'b0, 1'b0, 1'b0, 3'd5, got);   // mid pass
        send_req(REQ_PASS_START, 1'b1, 1'b0, 1'b0, 3'd0, got);   // pass restarted
        send_req(REQ_BIT_PAIR,   1'b0, 1'b0, 1'b0, 3'd0, got);
        send_req(REQ_BIT_PAIR,   1'b0, 1'b1, 1'b1, 3'd0, got);   // no response
        send_req(REQ_BIT_PAIR,   1'b0, 1'b1, 1'b0, 3'd0, got);   // search cleared
        send_req(REQ_PASS_START, 1'b1, 1'b0, 1'b0, 3'd0, got);
        send_req(REQ_BIT_PAIR,   1'b0, 1'b1, 1'b0, 3'd0, got);
        send_req(REQ_PASS_START, 1'b0, 1'b0, 1'b0, 3'd0, got);   // presence lost
        send_req(REQ_BIT_PAIR,   1'b0, 1'b0, 1'b1, 3'd0, got);
        send_req(REQ_RESTART,    1'b0, 1'b0, 1'b0, 3'd0, got);
        wait_all_results();
    endtask

    // All-zero and all-one ROMs, a lone device, discrepancies at bits 1 and 64
    task automatic test_bus_extremes();
        logic [ROM_W-1:0] base;
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
        bus_devices.delete();
        bus_devices.push_back('0);
        bus_devices.push_back('1);
        run_search(0);
        load_devices(1, 0);
        run_search(0);
        base = {$urandom, $urandom};
        bus_devices.delete();
        bus_devices.push_back(base);
        bus_devices.push_back(base ^ 64'h1);
        bus_devices.push_back(base ^ (64'h1 << (ROM_W - 1)));
        run_search(0);
        wait_all_results();
    endtask

    // Exactly as many devices as table entries: the last one completes it
    task automatic test_full_table();
        src_quiet  = 1'b0;
        sink_quiet = 1'b1;
        load_devices(TABLE_DEPTH, 3);
        run_search(0);
        wait_all_results();
    endtask

    // More devices than entries: the table fills while devices remain
    task automatic test_table_limit();
        src_quiet  = 1'b1;
        sink_quiet = 1'b0;
        load_devices(TABLE_DEPTH + 2, 0);
        run_search(0);
        wait_all_results();
    endtask

    // Mostly small searches with random content and some noise, plus bursts
    // of arbitrary requests; idling modes change from round to round
    task automatic test_random_searches();
        search_rsp_t got;
        while (items_sent < ITEM_TARGET)
        begin
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(10, 40))
                    send_req(req_type_t'(2'($urandom_range(0, 3))),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), got);
            else
            begin
                load_devices($urandom_range(1, 4), $urandom_range(0, 4));
                run_search($urandom_range(0, 12));
            end
            if ($urandom_range(0, 2) == 0)
                wait_all_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_RESTART;
        req_bus.presence     = 1'b0;
        req_bus.id_bit       = 1'b0;
        req_bus.cmp_bit      = 1'b0;
        req_bus.device_index = '0;
        req_up               = 1'b0;
        src_quiet            = 1'b1;
        sink_quiet           = 1'b1;
        items_sent           = 0;
        results_seen         = 0;
        mismatches           = 0;
        searches_run         = 0;
        roms_stored          = 0;
        clear_search_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_bus_extremes();
        test_full_table();
        test_table_limit();
        test_random_searches();

        // drain, then a few cycles more to catch stray results
        wait_all_results();
        repeat (8) @(posedge clk);

        $display("Run covered %0d request and %0d result transactions in %0d searches.",
                 items_sent, results_seen, searches_run);
        $display("ROMs stored by the search: %0d, including full-table and limit cases.",
                 roms_stored);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("PASS onewire_rom_search_engine_unit");
        else
            $display("FAIL onewire_rom_search_engine_unit");
        $finish;
    end

endmodule
